>>> src/irm_pkg.sv
// irm_pkg: shared constants, codes and types of the interval range map
// used by irm_cell and interval_range_map; no dependencies
`default_nettype none

package irm_pkg;

    // table geometry
    localparam int MAX_BOUNDARIES = 32;
    localparam int KEY_BITS       = 32;
    localparam int VAL_BITS       = 8;
    localparam int STATUS_BITS    = 2;

    // stream payload layout
    localparam int KB_LSB       = 0;
    localparam int KE_LSB       = KEY_BITS;
    localparam int NV_LSB       = 2 * KEY_BITS;
    localparam int KL_LSB       = 2 * KEY_BITS + VAL_BITS;
    localparam int S_TDATA_BITS = ((3 * KEY_BITS + VAL_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VAL_BITS + STATUS_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - VAL_BITS - STATUS_BITS;

    // default value after reset
    localparam logic [VAL_BITS-1:0] DEFAULT_RESET = VAL_BITS'(65);

    // item kinds
    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] RES_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] RES_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] RES_FULL  = 2'd2;

    // cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_CMP  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_INS  = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic [1:0]          op;
        logic [KEY_BITS-1:0] opa;       // compared with <
        logic [KEY_BITS-1:0] opb;       // compared with <=
        logic [KEY_BITS-1:0] load_key;
        logic [VAL_BITS-1:0] load_val;
    } cell_ctrl_t;

    // contents a cell shows to its neighbors
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] val;
        logic                ltb;       // key below range begin
        logic                del;       // key inside removed span
    } cell_link_t;

endpackage

`default_nettype wire

>>> src/irm_cell.sv
// irm_cell: one boundary slot of the sorted chain
// compares against broadcast keys and shifts with its neighbors; uses irm_pkg
`default_nettype none

module irm_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire irm_pkg::cell_ctrl_t ctrl,
    input  wire irm_pkg::cell_link_t left_i,
    input  wire irm_pkg::cell_link_t right_i,
    output irm_pkg::cell_link_t      self_o,
    output logic                     le_o
);

    logic                         valid_reg, valid_next;
    logic [irm_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [irm_pkg::VAL_BITS-1:0] val_reg, val_next;
    logic                         ltb_reg, ltb_next;
    logic                         del_reg, del_next;
    logic                         le_reg, le_next;
    logic                         below_a;
    logic                         upto_b;

    // key compares against the broadcast operands
    assign below_a = key_reg < ctrl.opa;
    assign upto_b  = key_reg <= ctrl.opb;

    // per-cell update
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        ltb_next   = ltb_reg;
        del_next   = del_reg;
        le_next    = le_reg;
        case (ctrl.op)
            irm_pkg::OP_CMP: begin
                ltb_next = valid_reg && below_a;
                le_next  = valid_reg && upto_b;
                del_next = valid_reg && !below_a && upto_b;
            end
            irm_pkg::OP_DEL: begin
                // cells at or past the removed slot pull from the right
                if (!ltb_reg) begin
                    valid_next = right_i.valid;
                    key_next   = right_i.key;
                    val_next   = right_i.val;
                    ltb_next   = right_i.ltb;
                    del_next   = right_i.del;
                end
            end
            irm_pkg::OP_INS: begin
                // insert slot loads the new entry, cells after it push right
                del_next = 1'b0;
                if (!ltb_reg) begin
                    if (left_i.ltb) begin
                        valid_next = 1'b1;
                        key_next   = ctrl.load_key;
                        val_next   = ctrl.load_val;
                    end else begin
                        valid_next = left_i.valid;
                        key_next   = left_i.key;
                        val_next   = left_i.val;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ltb_reg   <= 1'b0;
            del_reg   <= 1'b0;
            le_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            ltb_reg   <= ltb_next;
            del_reg   <= del_next;
            le_reg    <= le_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign self_o.valid = valid_reg;
    assign self_o.key   = key_reg;
    assign self_o.val   = val_reg;
    assign self_o.ltb   = ltb_reg;
    assign self_o.del   = del_reg;
    assign le_o         = le_reg;

endmodule

`default_nettype wire

>>> src/interval_range_map.sv
// interval_range_map: sorted boundary table as a chain of irm_cell slots
// sequence: lookup runs S_CMP, S_EVAL, S_DONE; assign runs S_CMP, S_EVAL, S_DEL
//   (one removed boundary per step), S_INS_E and S_INS_B for the 0 to 2 boundaries
//   inserted, then S_DONE; an empty range goes straight to S_DONE, a full refusal
//   from S_EVAL to S_DONE; one transaction at a time, one slot shift per cycle
// reset: aresetn synchronous active low; table empty, default value 65
// depends on irm_pkg and irm_cell
`default_nettype none

module interval_range_map (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: key_begin, key_end, new_value, lookup_key
    input  wire logic [irm_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // tuser: cmd
    input  wire logic                              s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: value, status, zero fill
    output logic [irm_pkg::M_TDATA_BITS-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // default_value register write
    input  wire logic [irm_pkg::VAL_BITS-1:0]      cfg_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready
);

    localparam int N = irm_pkg::MAX_BOUNDARIES;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DEL   = 3'd3;
    localparam logic [2:0] S_INS_E = 3'd4;
    localparam logic [2:0] S_INS_B = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic                            cmd_reg, cmd_next;
    logic [irm_pkg::KEY_BITS-1:0]    kb_reg, kb_next;
    logic [irm_pkg::KEY_BITS-1:0]    ke_reg, ke_next;
    logic [irm_pkg::KEY_BITS-1:0]    kl_reg, kl_next;
    logic [irm_pkg::VAL_BITS-1:0]    nv_reg, nv_next;
    logic                            pb_reg, pb_next;
    logic                            pe_reg, pe_next;
    logic [irm_pkg::VAL_BITS-1:0]    at_end_reg, at_end_next;
    logic [irm_pkg::VAL_BITS-1:0]    res_value_reg, res_value_next;
    logic [irm_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [irm_pkg::VAL_BITS-1:0]    m_value_reg, m_value_next;
    logic [irm_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [irm_pkg::VAL_BITS-1:0]    default_reg;

    irm_pkg::cell_ctrl_t             cell_ctrl;
    irm_pkg::cell_link_t             links [N];
    logic [N-1:0]                    le_vec;
    logic [N-1:0]                    ltb_vec;
    logic [N-1:0]                    del_vec;
    logic [N-1:0]                    valid_vec;

    logic [irm_pkg::KEY_BITS-1:0]    in_kb, in_ke, in_kl;
    logic [irm_pkg::VAL_BITS-1:0]    in_nv;
    logic [irm_pkg::VAL_BITS-1:0]    sel_ltb, sel_le;
    logic [irm_pkg::VAL_BITS-1:0]    before_val, end_val;
    logic                            put_b, put_e;
    logic                            del_none, del_le1, cnt_full, cnt_full1;
    logic                            refuse;
    logic                            out_free;

    // input payload fields
    assign in_kb = s_tdata[irm_pkg::KB_LSB +: irm_pkg::KEY_BITS];
    assign in_ke = s_tdata[irm_pkg::KE_LSB +: irm_pkg::KEY_BITS];
    assign in_nv = s_tdata[irm_pkg::NV_LSB +: irm_pkg::VAL_BITS];
    assign in_kl = s_tdata[irm_pkg::KL_LSB +: irm_pkg::KEY_BITS];

    // cell chain
    for (genvar i = 0; i < N; i++) begin : g_cell
        irm_pkg::cell_link_t left_l, right_l;
        if (i == 0) begin : g_first
            always_comb begin
                left_l       = '0;
                left_l.ltb   = 1'b1;
            end
        end else begin : g_mid
            assign left_l = links[i-1];
        end
        if (i == N - 1) begin : g_last
            assign right_l = '0;
        end else begin : g_inner
            assign right_l = links[i+1];
        end
        irm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .left_i  (left_l),
            .right_i (right_l),
            .self_o  (links[i]),
            .le_o    (le_vec[i])
        );
        assign ltb_vec[i]   = links[i].ltb;
        assign del_vec[i]   = links[i].del;
        assign valid_vec[i] = links[i].valid;
    end

    // value of the last slot under each prefix
    always_comb begin
        sel_ltb = '0;
        sel_le  = '0;
        for (int i = 0; i < N; i++) begin
            if (ltb_vec[i] && ((i == N - 1) || !ltb_vec[(i + 1) % N])) begin
                sel_ltb = sel_ltb | links[i].val;
            end
            if (le_vec[i] && ((i == N - 1) || !le_vec[(i + 1) % N])) begin
                sel_le = sel_le | links[i].val;
            end
        end
    end

    assign before_val = ltb_vec[0] ? sel_ltb : default_reg;
    assign end_val    = le_vec[0] ? sel_le : default_reg;

    // capacity check from valid prefix and removed span
    assign put_b     = before_val != nv_reg;
    assign put_e     = end_val != nv_reg;
    assign del_none  = del_vec == '0;
    assign del_le1   = (del_vec & (del_vec - N'(1))) == '0;
    assign cnt_full  = valid_vec[N-1];
    assign cnt_full1 = valid_vec[N-2] && !valid_vec[N-1];
    always_comb begin
        if (put_b && put_e) begin
            refuse = (cnt_full && del_le1) || (cnt_full1 && del_none);
        end else if (put_b || put_e) begin
            refuse = cnt_full && del_none;
        end else begin
            refuse = 1'b0;
        end
    end

    // broadcast command to the chain
    always_comb begin
        cell_ctrl.op       = irm_pkg::OP_HOLD;
        cell_ctrl.opa      = kb_reg;
        cell_ctrl.opb      = (cmd_reg == irm_pkg::CMD_LOOKUP) ? kl_reg : ke_reg;
        cell_ctrl.load_key = kb_reg;
        cell_ctrl.load_val = nv_reg;
        case (state_reg)
            S_CMP: begin
                cell_ctrl.op = irm_pkg::OP_CMP;
            end
            S_DEL: begin
                if (!del_none) begin
                    cell_ctrl.op = irm_pkg::OP_DEL;
                end
            end
            S_INS_E: begin
                cell_ctrl.op       = irm_pkg::OP_INS;
                cell_ctrl.load_key = ke_reg;
                cell_ctrl.load_val = at_end_reg;
            end
            S_INS_B: begin
                cell_ctrl.op = irm_pkg::OP_INS;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        kb_next         = kb_reg;
        ke_next         = ke_reg;
        kl_next         = kl_reg;
        nv_next         = nv_reg;
        pb_next         = pb_reg;
        pe_next         = pe_reg;
        at_end_next     = at_end_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_tuser;
                    kb_next         = in_kb;
                    ke_next         = in_ke;
                    kl_next         = in_kl;
                    nv_next         = in_nv;
                    res_value_next  = '0;
                    res_status_next = irm_pkg::RES_OK;
                    if (s_tuser == irm_pkg::CMD_ASSIGN && in_kb >= in_ke) begin
                        res_status_next = irm_pkg::RES_EMPTY;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (cmd_reg == irm_pkg::CMD_LOOKUP) begin
                    res_value_next = end_val;
                    state_next     = S_DONE;
                end else if (refuse) begin
                    res_status_next = irm_pkg::RES_FULL;
                    state_next      = S_DONE;
                end else begin
                    pb_next     = put_b;
                    pe_next     = put_e;
                    at_end_next = end_val;
                    state_next  = S_DEL;
                end
            end
            S_DEL: begin
                // one removed slot per cycle until the span is gone
                if (del_none) begin
                    if (pe_reg) begin
                        state_next = S_INS_E;
                    end else if (pb_reg) begin
                        state_next = S_INS_B;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS_E: begin
                state_next = pb_reg ? S_INS_B : S_DONE;
            end
            S_INS_B: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            default_reg <= irm_pkg::DEFAULT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                default_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        kb_reg         <= kb_next;
        ke_reg         <= ke_next;
        kl_reg         <= kl_next;
        nv_reg         <= nv_next;
        pb_reg         <= pb_next;
        pe_reg         <= pe_next;
        at_end_reg     <= at_end_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    // outputs
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{irm_pkg::M_PAD_BITS{1'b0}}, m_status_reg, m_value_reg};

endmodule

`default_nettype wire
